// ----- rtl/core/lzw_compressor_macros.svh -----
`ifndef LZW_COMPRESSOR_MACROS_SVH
`define LZW_COMPRESSOR_MACROS_SVH

// same-cycle implication on clk, off while rst_n is low
`define LZWC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off while rst_n is low
`define LZWC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lzwc_pkg.sv -----
package lzwc_pkg;

  localparam int SYM_W = 6;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HRD,
    S_PRD,
    S_CHK,
    S_MISS,
    S_FIN
  } lzwc_state_t;

  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic latch_cand;
    logic step;
    logic hit;
    logic miss;
    logic fin;
  } lzwc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pvalid;
    logic eos;
    logic live;
    logic match;
    logic out_free;
  } lzwc_stat_t;

endpackage

// ----- rtl/core/lzw_compressor.sv -----
// A dictionary hit passes through S_IDLE, S_HRD, S_PRD and S_CHK; a miss adds S_MISS, held
// while an output beat is pending; each hash collision adds one more read of the slot and
// pair memories. One symbol in flight; with no prefix held, S_IDLE alone takes a symbol.
// End of stream adds S_FIN for the final code, then the stream state clears.
// Reset: synchronous, active low; then S_CLEAR clears all 2**CODE_BITS (4096 by default)
// slots of the slot memory, with in_ready low throughout.
`include "lzw_compressor_macros.svh"

module lzw_compressor import lzwc_pkg::*; #(
  parameter int CODE_BITS     = 12,
  parameter int ALPHABET_SIZE = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SYM_W-1:0]     in_symbol,
  input  logic                 in_end_of_stream,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_BITS-1:0] out_code,
  output logic                 out_final_code
);

  lzwc_cmd_t  cmd;
  lzwc_stat_t stat;

  lzwc_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_end_of_stream (in_end_of_stream),
    .in_ready         (in_ready),
    .stat             (stat),
    .cmd              (cmd)
  );

  lzwc_datapath #(
    .CODE_BITS     (CODE_BITS),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_symbol        (in_symbol),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code         (out_code),
    .out_final_code   (out_final_code)
  );

  `LZWC_ASSERT_IMP(a_emit_slot_free, cmd.miss || cmd.fin, stat.out_free, "code issued while output beat pending")
  `LZWC_ASSERT_NXT(a_miss_emits, cmd.miss, out_valid && !out_final_code, "miss code not presented")
  `LZWC_ASSERT_NXT(a_fin_emits, cmd.fin, out_valid && out_final_code, "final code not presented")

endmodule

// ----- rtl/core/lzwc_ram.sv -----
module lzwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/lzwc_datapath.sv -----
module lzwc_datapath import lzwc_pkg::*; #(
  parameter int CODE_BITS     = 12,
  parameter int ALPHABET_SIZE = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lzwc_cmd_t            cmd,
  output lzwc_stat_t           stat,
  input  logic [SYM_W-1:0]     in_symbol,
  input  logic                 in_end_of_stream,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CODE_BITS-1:0] out_code,
  output logic                 out_final_code
);

  localparam int CB    = CODE_BITS;
  localparam int DEPTH = 2 ** CB;
  localparam int PW    = 2 * CB + SYM_W;

  logic [CB-1:0]    prefix_r;
  logic             pvalid_r;
  logic [CB:0]      next_free_r;
  logic [CB-1:0]    clr_cnt_r;
  logic             eos_r;
  logic             out_valid_r;
  logic [SYM_W-1:0] sym_r;
  logic [CB-1:0]    slot_r;
  logic [CB-1:0]    cand_r;
  logic [CB-1:0]    out_code_r;
  logic             out_final_r;

  logic [SYM_W-1:0] sym_sat;
  logic [CB-1:0]    slot_nxt;
  logic             full;
  logic             ins;
  logic             out_free;
  logic             in_range;

  logic             h_we;
  logic [CB-1:0]    h_waddr;
  logic [CB-1:0]    h_wdata;
  logic [CB-1:0]    h_rdata;
  logic [PW-1:0]    p_wdata;
  logic [PW-1:0]    p_rdata;
  logic [CB-1:0]    p_pre;
  logic [SYM_W-1:0] p_sym;
  logic [CB-1:0]    p_slot;

  assign sym_sat  = (int'(in_symbol) >= ALPHABET_SIZE) ? SYM_W'(ALPHABET_SIZE - 1) : in_symbol;
  assign slot_nxt = prefix_r ^ (CB'(sym_sat) << (CB - SYM_W));
  assign full     = next_free_r[CB];
  assign ins      = cmd.miss && !full;
  assign out_free = !out_valid_r || out_ready;

  assign h_we    = cmd.clr_wr || ins;
  assign h_waddr = cmd.clr_wr ? clr_cnt_r : slot_r;
  assign h_wdata = cmd.clr_wr ? '0 : next_free_r[CB-1:0];
  assign p_wdata = {prefix_r, sym_r, slot_r};
  assign {p_pre, p_sym, p_slot} = p_rdata;

  // slot index memory: hash slot -> code
  lzwc_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_hash_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (slot_r),
    .rdata (h_rdata)
  );

  // pair memory: code -> {prefix, symbol, owning slot}
  lzwc_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pair_ram (
    .clk   (clk),
    .we    (ins),
    .waddr (next_free_r[CB-1:0]),
    .wdata (p_wdata),
    .raddr (h_rdata),
    .rdata (p_rdata)
  );

  // a slot is live only if its code belongs to this stream and points back at it
  assign in_range = (int'(cand_r) >= ALPHABET_SIZE) && ({1'b0, cand_r} < next_free_r);

  always_comb begin
    stat.clr_last = &clr_cnt_r;
    stat.pvalid   = pvalid_r;
    stat.eos      = eos_r;
    stat.live     = in_range && (p_slot == slot_r);
    stat.match    = stat.live && (p_pre == prefix_r) && (p_sym == sym_r);
    stat.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r    <= '0;
      pvalid_r    <= 1'b0;
      next_free_r <= (CB+1)'(ALPHABET_SIZE);
      clr_cnt_r   <= '0;
      eos_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.accept) begin
        eos_r <= in_end_of_stream;
        if (!pvalid_r) begin
          prefix_r <= CB'(sym_sat);
          pvalid_r <= 1'b1;
        end
      end
      if (cmd.hit) begin
        prefix_r <= cand_r;
      end
      if (cmd.miss) begin
        prefix_r <= CB'(sym_r);
        if (!full) begin
          next_free_r <= next_free_r + 1'b1;
        end
      end
      if (cmd.fin) begin
        prefix_r    <= '0;
        pvalid_r    <= 1'b0;
        next_free_r <= (CB+1)'(ALPHABET_SIZE);
      end
      if (cmd.miss || cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sym_r  <= sym_sat;
      slot_r <= slot_nxt;
    end
    if (cmd.step) begin
      slot_r <= slot_r + 1'b1;
    end
    if (cmd.latch_cand) begin
      cand_r <= h_rdata;
    end
    if (cmd.miss || cmd.fin) begin
      out_code_r  <= prefix_r;
      out_final_r <= cmd.fin;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code       = out_code_r;
  assign out_final_code = out_final_r;

endmodule

// ----- rtl/core/lzwc_ctrl.sv -----
module lzwc_ctrl import lzwc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_end_of_stream,
  output logic       in_ready,
  input  lzwc_stat_t stat,
  output lzwc_cmd_t  cmd
);

  lzwc_state_t state_r;
  lzwc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.pvalid) begin
            state_nxt = S_HRD;
          end else if (in_end_of_stream) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_HRD: begin
        state_nxt = S_PRD;
      end
      S_PRD: begin
        cmd.latch_cand = 1'b1;
        state_nxt      = S_CHK;
      end
      S_CHK: begin
        if (stat.match) begin
          cmd.hit   = 1'b1;
          state_nxt = stat.eos ? S_FIN : S_IDLE;
        end else if (stat.live) begin
          cmd.step  = 1'b1;
          state_nxt = S_HRD;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        if (stat.out_free) begin
          cmd.miss  = 1'b1;
          state_nxt = stat.eos ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sim/tb_lzw_compressor.sv -----
`timescale 1ns / 100ps

module tb_lzw_compressor;
  import lzwc_pkg::SYM_W;

  localparam int CODE_W      = 12;
  localparam int ALPHA       = 64;
  localparam int DICT_SIZE   = 1 << CODE_W;
  localparam int PHASE_ITEMS = 362;
  localparam int BY_MODEL    = -1;
  localparam int CYCLE_LIMIT = 10_000_000;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } code_beat_t;

  typedef struct {
    logic [SYM_W-1:0]  sym;
    logic              eos;
    int                n_typed;
    logic [CODE_W-1:0] c0;
    logic              f0;
    logic [CODE_W-1:0] c1;
    logic              f1;
  } script_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [SYM_W-1:0]  in_symbol;
  logic              in_end_of_stream;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CODE_W-1:0] out_code;
  logic              out_final_code;

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int cycles    = 0;

  code_beat_t pending_codes[$];
  code_beat_t got_beat;

  // encoder mirror; pair entries are valid only when stamped with the current stream
  logic [CODE_W-1:0] held_code;
  bit                held;
  int                free_code;
  int                stream_id;
  logic [CODE_W-1:0] pair_code [0:(1<<(CODE_W+SYM_W))-1];
  int                pair_stream [0:(1<<(CODE_W+SYM_W))-1];

  lzw_compressor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_symbol        (in_symbol),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code         (out_code),
    .out_final_code   (out_final_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        errors++;
        $error("unexpected beat: code %0d final_code %0d", out_code, out_final_code);
      end else begin
        got_beat = pending_codes.pop_front();
        if (out_code !== got_beat.code) begin
          errors++;
          $error("code: expected %0d, got %0d", got_beat.code, out_code);
        end
        if (out_final_code !== got_beat.last) begin
          errors++;
          $error("final_code: expected %0d, got %0d", got_beat.last, out_final_code);
        end
      end
    end
  end

  function automatic void expect_beat(logic [CODE_W-1:0] code, logic fin);
    code_beat_t b;
    b.code = code;
    b.last = fin;
    pending_codes = {pending_codes, b};
  endfunction

  function automatic bit pair_known(logic [CODE_W-1:0] pre, logic [SYM_W-1:0] s);
    return pair_stream[{pre, s}] == stream_id;
  endfunction

  function automatic void encode_symbol(logic [SYM_W-1:0] s, logic eos, bit keep);
    logic [CODE_W+SYM_W-1:0] key;
    key = {held_code, s};
    if (!held) begin
      held_code = CODE_W'(s);
      held = 1'b1;
    end else if (pair_stream[key] == stream_id) begin
      held_code = pair_code[key];
    end else begin
      if (keep) expect_beat(held_code, 1'b0);
      if (free_code < DICT_SIZE) begin
        pair_code[key]   = CODE_W'(free_code);
        pair_stream[key] = stream_id;
        free_code++;
      end
      held_code = CODE_W'(s);
    end
    if (eos) begin
      if (keep) expect_beat(held_code, 1'b1);
      held_code = '0;
      held = 1'b0;
      free_code = ALPHA;
      stream_id++;
    end
  endfunction

  task automatic send_symbol(logic [SYM_W-1:0] s, logic eos, bit keep);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_symbol        <= s;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_symbol(s, eos, keep);
  endtask

  // prefers a symbol that misses against the held prefix, to grow the dictionary fast
  function automatic logic [SYM_W-1:0] fresh_symbol();
    logic [SYM_W-1:0] s;
    s = SYM_W'($urandom_range(ALPHA - 1));
    for (int t = 0; t < 8 && held && pair_known(held_code, s); t++)
      s = SYM_W'($urandom_range(ALPHA - 1));
    return s;
  endfunction

  initial begin
    script_row_t script [24];
    int n_items;
    int len;
    int base;
    int span;
    logic [SYM_W-1:0] s;

    held      = 1'b0;
    held_code = '0;
    free_code = ALPHA;
    stream_id = 1;

    script = '{
      '{6'd0,  1'b1, 1,        12'd0,  1'b1, 12'd0, 1'b0},
      '{6'd63, 1'b1, 1,        12'd63, 1'b1, 12'd0, 1'b0},
      '{6'd5,  1'b0, 0,        12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd5,  1'b0, 1,        12'd5,  1'b0, 12'd0, 1'b0},
      '{6'd5,  1'b0, 0,        12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd5,  1'b0, 1,        12'd64, 1'b0, 12'd0, 1'b0},
      '{6'd5,  1'b0, 0,        12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd5,  1'b0, 0,        12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd5,  1'b1, 2,        12'd65, 1'b0, 12'd5, 1'b1},
      '{6'd5,  1'b0, 0,        12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd5,  1'b1, 2,        12'd5,  1'b0, 12'd5, 1'b1},
      '{6'd63, 1'b0, 0,        12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd0,  1'b0, 1,        12'd63, 1'b0, 12'd0, 1'b0},
      '{6'd63, 1'b0, 1,        12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd0,  1'b1, 1,        12'd64, 1'b1, 12'd0, 1'b0},
      '{6'd63, 1'b0, 0,        12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd63, 1'b0, 1,        12'd63, 1'b0, 12'd0, 1'b0},
      '{6'd63, 1'b1, 1,        12'd64, 1'b1, 12'd0, 1'b0},
      '{6'd42, 1'b0, BY_MODEL, 12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd21, 1'b0, BY_MODEL, 12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd42, 1'b0, BY_MODEL, 12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd21, 1'b0, BY_MODEL, 12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd42, 1'b0, BY_MODEL, 12'd0,  1'b0, 12'd0, 1'b0},
      '{6'd21, 1'b1, BY_MODEL, 12'd0,  1'b0, 12'd0, 1'b0}
    };

    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_symbol        <= '0;
    in_end_of_stream <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      send_symbol(script[i].sym, script[i].eos, script[i].n_typed == BY_MODEL);
      if (script[i].n_typed >= 1) expect_beat(script[i].c0, script[i].f0);
      if (script[i].n_typed >= 2) expect_beat(script[i].c1, script[i].f1);
    end

    // idling phases: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 57 : (ph == 3) ? 34 : 0;
      stall_pct = (ph == 2) ? 57 : (ph == 3) ? 34 : 0;
      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        len  = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(8, 60);
        base = $urandom_range(ALPHA - 1);
        span = ($urandom_range(3) == 0) ? ALPHA : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          s = SYM_W'(base + $urandom_range(span - 1));
          send_symbol(s, k == len - 1, 1'b1);
        end
        n_items += len;
      end
    end

    // one stream long enough to fill the dictionary, then misses with no room left
    idle_pct  = 0;
    stall_pct = 0;
    send_symbol(fresh_symbol(), 1'b0, 1'b1);
    while (free_code < DICT_SIZE) send_symbol(fresh_symbol(), 1'b0, 1'b1);
    for (int k = 0; k < 6; k++) send_symbol(fresh_symbol(), k == 5, 1'b1);

    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lzwc_pkg.sv
rtl/core/lzwc_ram.sv
rtl/core/lzwc_datapath.sv
rtl/core/lzwc_ctrl.sv
rtl/core/lzw_compressor.sv
sim/tb_lzw_compressor.sv
